>>> src/isrt_pkg.sv
// ----------------------------------------------------------------------------
// isrt_pkg: shared types and codes for the interval set range tracker
// Operation codes and the span type used when building a new range table.
// ----------------------------------------------------------------------------
package isrt_pkg;

    localparam logic [1:0] KIND_COMPLETE   = 2'd0;
    localparam logic [1:0] KIND_INCOMPLETE = 2'd1;
    localparam logic [1:0] KIND_HAVE       = 2'd2;
    localparam logic [1:0] KIND_FIRST_GAP  = 2'd3;

    localparam logic [31:0] TOP_END = 32'hFFFF_FFFF;

    // One half-open byte range [s, e).
    typedef struct packed {
        logic [31:0] s;
        logic [31:0] e;
    } t_span;

endpackage

>>> src/interval_set_range_tracker_core.sv
// ----------------------------------------------------------------------------
// interval_set_range_tracker_core: sorted table of disjoint byte ranges
// Mark and have items read and process each stored range in turn (a split
// range adds a push), then finish; first-gap and empty marks skip to the
// result. One item at a time (busy is high), paced by single read/write ports.
// Reset (synchronous, active low) empties the table; no clearing pass is run.
// Each result is shown for one cycle under o_result_valid; it cannot be stalled.
// ----------------------------------------------------------------------------
module interval_set_range_tracker_core
    import isrt_pkg::*;
#(
    parameter int MAX_RANGES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Item command channel.
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_offset,
    input  logic [31:0] i_length,
    // Configuration write channel (total_size).
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // Result strobe and fields.
    output logic        o_result_valid,
    output logic        o_covered,
    output logic [31:0] o_gap_offset,
    output logic [31:0] o_gap_length,
    output logic        o_all_complete,
    output logic [31:0] o_bytes_completed,
    output logic [6:0]  o_range_count,
    output logic        o_table_full
);

    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_PROC  = 3'd2;
    localparam logic [2:0] ST_PUSH2 = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // The table lives in two banks of one memory. A mark item reads the
    // live bank entry by entry and builds the new table in the other bank;
    // on success the bank select flips, so no copy back is needed. A
    // rejected mark simply leaves the select alone.
    logic [31:0] mem_s [2][MAX_RANGES];
    logic [31:0] mem_e [2][MAX_RANGES];
    logic [31:0] r_rd_s, r_rd_e;

    logic [2:0]    r_state, n_state;
    logic          r_bank;
    logic [CW-1:0] r_live;
    logic [31:0]   r_total;
    logic [31:0]   r_sum;
    // Cached copies of the first two entries for first-gap and completion.
    logic [31:0]   r_s0, r_e0, r_s1;

    // Item registers.
    logic [1:0]    r_kind;
    logic [31:0]   r_off;
    logic [32:0]   r_s, n_s;
    logic [32:0]   r_e, n_e;
    logic          r_placed, n_placed;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic [31:0]   r_nsum, n_nsum;
    logic [31:0]   r_t0s, n_t0s, r_t0e, n_t0e, r_t1s, n_t1s;
    t_span         r_stash, n_stash;
    logic          r_cov, n_cov;
    logic [31:0]   r_goff, r_glen;

    // Push candidates for this cycle.
    logic          v1, v2;
    t_span         p1, p2;
    logic          p_v;
    t_span         p;
    logic          w_en;

    logic [32:0] rs33, re33, end33;
    logic        last_entry;

    // First-gap arithmetic at item start.
    logic [32:0] g_o, g_l, g_sum;
    logic [32:0] mc_end;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign rs33       = {1'b0, r_rd_s};
    assign re33       = {1'b0, r_rd_e};
    assign end33      = {1'b0, i_offset} + {1'b0, i_length};
    assign last_entry = ((r_idx + 1'b1) == r_live);

    always_comb begin
        mc_end = end33;
        if (mc_end > {1'b0, TOP_END}) begin
            mc_end = {1'b0, TOP_END};
        end
    end

    // First gap from the cached head of the table.
    always_comb begin
        if (r_live == '0) begin
            g_o = '0;
            g_l = {1'b0, i_length};
        end else if (r_s0 != '0) begin
            g_o = '0;
            g_l = {1'b0, r_s0};
        end else if (r_live == CW'(1)) begin
            g_o = {1'b0, r_e0};
            g_l = {1'b0, i_length};
        end else begin
            g_o = {1'b0, r_e0};
            g_l = {1'b0, r_s1} - {1'b0, r_e0};
        end
        if (g_l > {1'b0, i_length}) begin
            g_l = {1'b0, i_length};
        end
        g_sum = g_o + g_l;
        if ({1'b0, r_total} < g_sum) begin
            g_l = (g_o >= {1'b0, r_total}) ? 33'd0 : ({1'b0, r_total} - g_o);
        end
    end

    // Per-entry decision and the push it causes.
    always_comb begin
        v1       = 1'b0;
        v2       = 1'b0;
        p1       = '0;
        p2       = '0;
        n_s      = r_s;
        n_e      = r_e;
        n_placed = r_placed;
        n_cov    = r_cov;
        n_stash  = r_stash;
        if (r_state == ST_PROC) begin
            case (r_kind)
                KIND_COMPLETE: begin
                    if (re33 < r_s) begin
                        v1 = 1'b1;
                        p1 = '{s: r_rd_s, e: r_rd_e};
                    end else if (rs33 > r_e) begin
                        if (!r_placed) begin
                            v1       = 1'b1;
                            p1       = '{s: r_s[31:0], e: r_e[31:0]};
                            v2       = 1'b1;
                            p2       = '{s: r_rd_s, e: r_rd_e};
                            n_placed = 1'b1;
                        end else begin
                            v1 = 1'b1;
                            p1 = '{s: r_rd_s, e: r_rd_e};
                        end
                    end else begin
                        if (rs33 < r_s) begin
                            n_s = rs33;
                        end
                        if (re33 > r_e) begin
                            n_e = re33;
                        end
                    end
                end
                KIND_INCOMPLETE: begin
                    if (rs33 < r_s) begin
                        v1 = 1'b1;
                        p1 = '{s: r_rd_s, e: (re33 < r_s) ? r_rd_e : r_s[31:0]};
                    end
                    if (re33 > r_e) begin
                        v2 = 1'b1;
                        p2 = '{s: (rs33 > r_e) ? r_rd_s : r_e[31:0], e: r_rd_e};
                    end
                end
                KIND_HAVE: begin
                    if ((r_rd_s <= r_off) && (r_e <= re33)) begin
                        n_cov = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (v1 && v2) begin
                n_stash = p2;
            end
        end
    end

    // Single write port: choose what is pushed this cycle.
    always_comb begin
        p_v = 1'b0;
        p   = '0;
        case (r_state)
            ST_PROC: begin
                p_v = v1 | v2;
                p   = v1 ? p1 : p2;
            end
            ST_PUSH2: begin
                p_v = 1'b1;
                p   = r_stash;
            end
            ST_FIN: begin
                p_v = (r_kind == KIND_COMPLETE) && !r_placed;
                p   = '{s: r_s[31:0], e: r_e[31:0]};
            end
            default: begin
            end
        endcase
    end

    // Scratch bookkeeping for the table being built.
    always_comb begin
        logic [32:0] acc;
        acc    = '0;
        n_cnt  = r_cnt;
        n_ovf  = r_ovf;
        n_nsum = r_nsum;
        n_t0s  = r_t0s;
        n_t0e  = r_t0e;
        n_t1s  = r_t1s;
        w_en   = 1'b0;
        if (p_v) begin
            if (r_cnt == MAX_CNT) begin
                n_ovf = 1'b1;
            end else begin
                w_en  = 1'b1;
                n_cnt = r_cnt + 1'b1;
                acc   = {1'b0, r_nsum} + {1'b0, p.e - p.s};
                n_nsum = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
                if (r_cnt == '0) begin
                    n_t0s = p.s;
                    n_t0e = p.e;
                end
                if (r_cnt == CW'(1)) begin
                    n_t1s = p.s;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem_s[~r_bank][r_cnt[IW-1:0]] <= p.s;
            mem_e[~r_bank][r_cnt[IW-1:0]] <= p.e;
        end
        if (r_state == ST_READ) begin
            r_rd_s <= mem_s[r_bank][r_idx[IW-1:0]];
            r_rd_e <= mem_e[r_bank][r_idx[IW-1:0]];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_kind == KIND_FIRST_GAP) begin
                        n_state = ST_OUT;
                    end else if ((i_kind == KIND_COMPLETE) &&
                                 ((i_length == '0) || (mc_end <= {1'b0, i_offset}))) begin
                        n_state = ST_OUT;
                    end else if ((i_kind == KIND_INCOMPLETE) && (i_length == '0)) begin
                        n_state = ST_OUT;
                    end else if (r_live == '0) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: n_state = ST_PROC;
            ST_PROC: begin
                if (v1 && v2) begin
                    n_state = ST_PUSH2;
                end else begin
                    n_state = last_entry ? ST_FIN : ST_READ;
                end
            end
            ST_PUSH2: n_state = last_entry ? ST_FIN : ST_READ;
            ST_FIN:   n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bank  <= 1'b0;
            r_live  <= '0;
            r_total <= '0;
            r_sum   <= '0;
            r_s0    <= '0;
            r_e0    <= '0;
            r_s1    <= '0;
            r_cov   <= 1'b0;
            r_ovf   <= 1'b0;
            r_goff  <= '0;
            r_glen  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_total <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_kind   <= i_kind;
                        r_off    <= i_offset;
                        r_s      <= {1'b0, i_offset};
                        r_e      <= (i_kind == KIND_COMPLETE) ? mc_end : end33;
                        r_placed <= 1'b0;
                        r_idx    <= '0;
                        r_cnt    <= '0;
                        r_ovf    <= 1'b0;
                        r_nsum   <= '0;
                        r_cov    <= 1'b0;
                        r_goff   <= (i_kind == KIND_FIRST_GAP) ? g_o[31:0] : 32'd0;
                        r_glen   <= (i_kind == KIND_FIRST_GAP) ? g_l[31:0] : 32'd0;
                    end
                end
                ST_PROC, ST_PUSH2: begin
                    r_s      <= n_s;
                    r_e      <= n_e;
                    r_placed <= n_placed;
                    r_cov    <= n_cov;
                    r_stash  <= n_stash;
                    r_cnt    <= n_cnt;
                    r_ovf    <= n_ovf;
                    r_nsum   <= n_nsum;
                    r_t0s    <= n_t0s;
                    r_t0e    <= n_t0e;
                    r_t1s    <= n_t1s;
                    if ((r_state == ST_PUSH2) || !(v1 && v2)) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_FIN: begin
                    r_ovf <= n_ovf;
                    // Commit the new table unless it did not fit.
                    if (((r_kind == KIND_COMPLETE) || (r_kind == KIND_INCOMPLETE)) && !n_ovf) begin
                        r_bank <= ~r_bank;
                        r_live <= n_cnt;
                        r_sum  <= n_nsum;
                        r_s0   <= n_t0s;
                        r_e0   <= n_t0e;
                        r_s1   <= n_t1s;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result_valid    = (r_state == ST_OUT);
    assign o_covered         = r_cov;
    assign o_gap_offset      = r_goff;
    assign o_gap_length      = r_glen;
    assign o_all_complete    = (r_live == CW'(1)) && ((r_e0 - r_s0) == r_total);
    assign o_bytes_completed = r_sum;
    assign o_range_count     = 7'(r_live);
    assign o_table_full      = r_ovf;

endmodule
